// ===== hdl/jsd_pkg.sv =====
// Package for the escape decoder: payload and bundle types, escape state codes,
// character constants and small classification functions.
// No dependencies.
package jsd_pkg;

   localparam int unsigned MAX_RESULTS = 5;
   localparam int unsigned CNT_W       = 3;
   localparam int unsigned HELD_DEPTH  = 4;

   localparam logic [7:0] CH_BSLASH   = 8'h5c;
   localparam logic [7:0] CH_U        = 8'h75;
   localparam logic [7:0] CH_X        = 8'h78;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_THREE    = 8'h33;
   localparam logic [7:0] CH_SEVEN    = 8'h37;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_F  = 8'h46;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_F  = 8'h66;
   localparam logic [7:0] CASE_MASK   = 8'hdf;
   localparam logic [7:0] ALPHA_BIAS  = 8'h37;
   localparam logic [7:0] ADJ_LIMIT   = 8'h5f;
   localparam logic [7:0] ADJ_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BSLASH = 2'd1,
      KIND_HEX    = 2'd2,
      KIND_OCT    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // decoded bytes of one request, oldest in entry 0
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] res_bytes;
      logic [CNT_W-1:0]            count;
      logic                        last;
   } bundle_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_F) ||
             (c >= CH_UPPER_A && c <= CH_UPPER_F);
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_SEVEN;
   endfunction

   function automatic logic is_f(input logic [7:0] c);
      return c == CH_LOWER_F || c == CH_UPPER_F;
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      if (c >= CH_UPPER_A) begin
         t = (c & CASE_MASK) - ALPHA_BIAS;
      end else begin
         t = c - CH_ZERO;
      end
      return t[3:0];
   endfunction

   function automatic logic [7:0] named_code(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h61:   r = 8'h07;   // a
         8'h62:   r = 8'h08;   // b
         8'h66:   r = 8'h0c;   // f
         8'h6e:   r = 8'h0a;   // n
         8'h72:   r = 8'h0d;   // r
         8'h74:   r = 8'h09;   // t
         8'h76:   r = 8'h0b;   // v
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/jsd_front.sv =====
// Front end of the escape decoder: tracks the pending escape and turns each
// request into a bundle of up to five decoded bytes.
// Depends on jsd_pkg.
module jsd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  jsd_pkg::req_type    req,
   output logic                push,
   output jsd_pkg::bundle_type bundle
);

   jsd_pkg::kind_type                        kind_ff, kind_in, kind_mid;
   logic [jsd_pkg::CNT_W-1:0]                cnt_ff, cnt_in, cnt_mid;
   logic [jsd_pkg::HELD_DEPTH-1:0][7:0]      held_ff, held_in, held_mid;

   logic [jsd_pkg::MAX_RESULTS-1:0][7:0]     res;
   logic [jsd_pkg::CNT_W-1:0]                idx;
   logic                                     need_u;
   logic                                     hex_done;
   logic [7:0]                               hex_hi;
   logic [7:0]                               hex_v;
   logic [7:0]                               b;

   // value of an octal escape closed early with one or two digits
   function automatic logic [7:0] oct_short(input logic [7:0] d0, input logic [7:0] d1,
                                            input logic [jsd_pkg::CNT_W-1:0] n);
      logic [7:0] r;
      if (n == 3'd1) begin
         r = {5'b0, d0[2:0]};
      end else begin
         r = {2'b0, d0[2:0], d1[2:0]};
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= jsd_pkg::KIND_NONE;
         cnt_ff  <= '0;
      end else begin
         kind_ff <= kind_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_comb begin
      b        = req.in_byte;
      res      = '0;
      idx      = '0;
      kind_mid = kind_ff;
      cnt_mid  = cnt_ff;
      held_mid = held_ff;

      need_u   = held_ff[0] == jsd_pkg::CH_U;
      hex_done = need_u ? (cnt_ff == 3'd4) : (cnt_ff == 3'd2);
      hex_hi   = need_u ? held_ff[3] : held_ff[1];
      hex_v    = {jsd_pkg::hex_val(hex_hi), jsd_pkg::hex_val(b)};
      if (need_u && hex_v != 8'h00 && hex_v < jsd_pkg::ADJ_LIMIT &&
          jsd_pkg::is_f(held_ff[1]) && jsd_pkg::is_f(held_ff[2])) begin
         hex_v = hex_v + jsd_pkg::ADJ_OFFSET;
      end

      // feed the byte into the pending escape
      case (kind_ff)
         jsd_pkg::KIND_NONE: begin
            if (b == jsd_pkg::CH_BSLASH) begin
               kind_mid = jsd_pkg::KIND_BSLASH;
               cnt_mid  = '0;
            end else begin
               res[idx] = b;
               idx      = idx + 3'd1;
            end
         end
         jsd_pkg::KIND_BSLASH: begin
            if (b == jsd_pkg::CH_U || b == jsd_pkg::CH_X) begin
               held_mid[0] = b;
               cnt_mid     = 3'd1;
               kind_mid    = jsd_pkg::KIND_HEX;
            end else if (jsd_pkg::is_oct(b)) begin
               held_mid[0] = b;
               cnt_mid     = 3'd1;
               kind_mid    = jsd_pkg::KIND_OCT;
            end else begin
               res[idx] = jsd_pkg::named_code(b);
               idx      = idx + 3'd1;
               kind_mid = jsd_pkg::KIND_NONE;
            end
         end
         jsd_pkg::KIND_HEX: begin
            if (jsd_pkg::is_hex(b)) begin
               if (hex_done) begin
                  res[idx] = hex_v;
                  idx      = idx + 3'd1;
                  kind_mid = jsd_pkg::KIND_NONE;
                  cnt_mid  = '0;
               end else begin
                  held_mid[cnt_ff[1:0]] = b;
                  cnt_mid               = cnt_ff + 3'd1;
               end
            end else begin
               // failed escape: emit the letter and digits, then restart on b
               for (int k = 0; k < jsd_pkg::HELD_DEPTH; k++) begin
                  if (3'(k) < cnt_ff) begin
                     res[idx] = held_ff[k];
                     idx      = idx + 3'd1;
                  end
               end
               cnt_mid = '0;
               if (b == jsd_pkg::CH_BSLASH) begin
                  kind_mid = jsd_pkg::KIND_BSLASH;
               end else begin
                  kind_mid = jsd_pkg::KIND_NONE;
                  res[idx] = b;
                  idx      = idx + 3'd1;
               end
            end
         end
         jsd_pkg::KIND_OCT: begin
            if (jsd_pkg::is_oct(b)) begin
               if (cnt_ff == 3'd2) begin
                  if (held_ff[0] > jsd_pkg::CH_THREE) begin
                     res[idx] = {2'b0, held_ff[0][2:0], held_ff[1][2:0]};
                     idx      = idx + 3'd1;
                     res[idx] = b;
                     idx      = idx + 3'd1;
                  end else begin
                     res[idx] = {held_ff[0][1:0], held_ff[1][2:0], b[2:0]};
                     idx      = idx + 3'd1;
                  end
                  kind_mid = jsd_pkg::KIND_NONE;
                  cnt_mid  = '0;
               end else begin
                  held_mid[cnt_ff[1:0]] = b;
                  cnt_mid               = cnt_ff + 3'd1;
               end
            end else begin
               res[idx] = oct_short(held_ff[0], held_ff[1], cnt_ff);
               idx      = idx + 3'd1;
               cnt_mid  = '0;
               if (b == jsd_pkg::CH_BSLASH) begin
                  kind_mid = jsd_pkg::KIND_BSLASH;
               end else begin
                  kind_mid = jsd_pkg::KIND_NONE;
                  res[idx] = b;
                  idx      = idx + 3'd1;
               end
            end
         end
         default: begin
            kind_mid = jsd_pkg::KIND_NONE;
         end
      endcase

      // flush whatever is still pending at the end of the string
      if (req.in_last) begin
         case (kind_mid)
            jsd_pkg::KIND_BSLASH: begin
               res[idx] = jsd_pkg::CH_BSLASH;
               idx      = idx + 3'd1;
            end
            jsd_pkg::KIND_HEX: begin
               for (int k = 0; k < jsd_pkg::HELD_DEPTH; k++) begin
                  if (3'(k) < cnt_mid) begin
                     res[idx] = held_mid[k];
                     idx      = idx + 3'd1;
                  end
               end
            end
            jsd_pkg::KIND_OCT: begin
               res[idx] = oct_short(held_mid[0], held_mid[1], cnt_mid);
               idx      = idx + 3'd1;
            end
            default: begin
               idx = idx;
            end
         endcase
      end

      if (take) begin
         kind_in = req.in_last ? jsd_pkg::KIND_NONE : kind_mid;
         cnt_in  = req.in_last ? '0 : cnt_mid;
         held_in = held_mid;
      end else begin
         kind_in = kind_ff;
         cnt_in  = cnt_ff;
         held_in = held_ff;
      end

      push             = take && (idx != '0);
      bundle.res_bytes = res;
      bundle.count     = idx;
      bundle.last      = req.in_last;
   end

endmodule

// ===== hdl/jsd_queue.sv =====
// Short bundle queue between the front end and the output serializer.
// Depends on jsd_pkg.
module jsd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsd_pkg::bundle_type wr_data,
   input  logic                pop,
   output jsd_pkg::bundle_type rd_data,
   output logic                full,
   output logic                empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LVL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(DEPTH);

   jsd_pkg::bundle_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]      level_ff, level_in;
   logic                  do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = slot_ff[rd_ptr_ff];
   assign full    = level_ff == FULL_LVL;
   assign empty   = level_ff == '0;

endmodule

// ===== hdl/jsd_back.sv =====
// Back end of the escape decoder: walks the bundle at the queue head and
// hands out its bytes one per response, marking the string's final byte.
// Depends on jsd_pkg.
module jsd_back (
   input  logic                clock,
   input  logic                reset,
   input  jsd_pkg::bundle_type head,
   input  logic                head_empty,
   output logic                head_pop,
   output jsd_pkg::rsp_type    rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);

   logic [jsd_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic                      at_end;

   always_comb begin
      at_end            = pos_ff == (head.count - 3'd1);
      rsp_empty         = head_empty;
      rsp_data.out_byte = head.res_bytes[pos_ff];
      rsp_data.out_last = head.last && at_end;
      head_pop          = 1'b0;
      pos_in            = pos_ff;
      if (rsp_pop && !head_empty) begin
         if (at_end) begin
            // bundle drained: release it and restart at its successor
            head_pop = 1'b1;
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hdl/js_escape_decoder.sv =====
// Top level of the escape decoder: front end, bundle queue and output serializer.
// Depends on jsd_pkg, jsd_front, jsd_queue and jsd_back.
//
//   channel   direction  handshake            payload
//   req_      in         req_push / req_full  req_data  (in_byte, in_last)
//   rsp_      out        rsp_pop / rsp_empty  rsp_data  (out_byte, out_last)
//
// One request is decoded in the cycle it is accepted; the front end takes a
// request every cycle while the bundle queue (QUEUE_DEPTH entries) has room.
// Each response byte is handed out by the serializer on a popped response, so a
// request that decodes to n bytes holds the queue head until n bytes are popped
// (n from 1 to 5); a request that decodes to nothing never enters the queue.
// Reset is synchronous and clears the escape state, the queue and the serializer.
// A stalled response side backs up into the queue, then raises req_full.
module js_escape_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  jsd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output jsd_pkg::rsp_type rsp_data
);

   logic                take;
   logic                q_push;
   logic                q_pop;
   logic                q_empty;
   jsd_pkg::bundle_type q_wr;
   jsd_pkg::bundle_type q_head;

   assign take = req_push && !req_full;

   jsd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_data),
      .push   (q_push),
      .bundle (q_wr)
   );

   jsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_head),
      .full    (req_full),
      .empty   (q_empty)
   );

   jsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_empty (q_empty),
      .head_pop   (q_pop),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule

// ===== tb/jsd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the escape decoder: predicts the decoded bytes of every accepted
// request and compares each popped response with them in order.
// Depends on jsd_pkg.
module jsd_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  jsd_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  jsd_pkg::rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      waiting_count
);

   localparam int unsigned PRINT_LIMIT = 100;

   // decoder state as seen by the predictor
   logic [7:0]                esc_held [0:4];
   logic [jsd_pkg::CNT_W-1:0] esc_count;
   jsd_pkg::kind_type         esc_state;

   // bytes produced by the current request
   logic [7:0]       burst [0:7];
   int unsigned      burst_n;

   jsd_pkg::rsp_type decoded_q [$];

   initial begin
      mismatch_count = 0;
      waiting_count  = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t decode_check: %s", $time, msg);
      end
   endtask

   function automatic logic hex_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic octal_digit(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic logic f_char(input logic [7:0] c);
      return c == "f" || c == "F";
   endfunction

   // letters sit at x1..x6 in both cases, so add 9 to the low nibble
   function automatic logic [3:0] nibble(input logic [7:0] c);
      if (c <= "9") begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   function automatic logic [7:0] control_code(input logic [7:0] c);
      case (c)
         "a":     return 8'h07;
         "b":     return 8'h08;
         "f":     return 8'h0c;
         "n":     return 8'h0a;
         "r":     return 8'h0d;
         "t":     return 8'h09;
         "v":     return 8'h0b;
         default: return c;
      endcase
   endfunction

   function automatic logic [7:0] oct_join(input int unsigned n);
      logic [8:0] v;
      v = '0;
      for (int k = 0; k < n && k < 3; k++) begin
         v = {v[5:0], esc_held[k][2:0]};
      end
      return v[7:0];
   endfunction

   function automatic void emit_byte(input logic [7:0] b);
      if (burst_n < 8) begin
         burst[burst_n] = b;
         burst_n++;
      end
   endfunction

   function automatic void feed_plain(input logic [7:0] b);
      if (b == jsd_pkg::CH_BSLASH) begin
         esc_state = jsd_pkg::KIND_BSLASH;
         esc_count = '0;
      end else begin
         emit_byte(b);
      end
   endfunction

   // give back the letter and the digits held after it
   function automatic void flush_hex();
      for (int k = 0; k < esc_count; k++) begin
         emit_byte(esc_held[k]);
      end
      esc_state = jsd_pkg::KIND_NONE;
      esc_count = '0;
   endfunction

   function automatic void decode_request(input jsd_pkg::req_type r);
      logic [7:0]  b;
      logic [7:0]  v;
      int unsigned need;
      b = r.in_byte;
      burst_n = 0;
      case (esc_state)
         jsd_pkg::KIND_NONE: begin
            feed_plain(b);
         end
         jsd_pkg::KIND_BSLASH: begin
            if (b == jsd_pkg::CH_U || b == jsd_pkg::CH_X) begin
               esc_held[0] = b;
               esc_count   = 3'd1;
               esc_state   = jsd_pkg::KIND_HEX;
            end else if (octal_digit(b)) begin
               esc_held[0] = b;
               esc_count   = 3'd1;
               esc_state   = jsd_pkg::KIND_OCT;
            end else begin
               emit_byte(control_code(b));
               esc_state = jsd_pkg::KIND_NONE;
            end
         end
         jsd_pkg::KIND_HEX: begin
            if (hex_digit(b) && esc_count < 5) begin
               need = (esc_held[0] == jsd_pkg::CH_U) ? 5 : 3;
               esc_held[esc_count] = b;
               esc_count++;
               if (esc_count >= need) begin
                  v = {nibble(esc_held[need-2]), nibble(esc_held[need-1])};
                  if (need == 5 && v != 8'h00 && v < jsd_pkg::ADJ_LIMIT &&
                      f_char(esc_held[1]) && f_char(esc_held[2])) begin
                     v = v + jsd_pkg::ADJ_OFFSET;
                  end
                  emit_byte(v);
                  esc_state = jsd_pkg::KIND_NONE;
                  esc_count = '0;
               end
            end else begin
               flush_hex();
               feed_plain(b);
            end
         end
         default: begin
            if (octal_digit(b) && esc_count < 3) begin
               esc_held[esc_count] = b;
               esc_count++;
               if (esc_count == 3) begin
                  // a large first digit would overflow, so take two digits only
                  if (esc_held[0] > jsd_pkg::CH_THREE) begin
                     emit_byte(oct_join(2));
                     emit_byte(esc_held[2]);
                  end else begin
                     emit_byte(oct_join(3));
                  end
                  esc_state = jsd_pkg::KIND_NONE;
                  esc_count = '0;
               end
            end else begin
               emit_byte(oct_join(esc_count));
               esc_state = jsd_pkg::KIND_NONE;
               esc_count = '0;
               feed_plain(b);
            end
         end
      endcase

      // flush whatever is pending at the end of the string
      if (r.in_last) begin
         case (esc_state)
            jsd_pkg::KIND_BSLASH: emit_byte(jsd_pkg::CH_BSLASH);
            jsd_pkg::KIND_HEX:    flush_hex();
            jsd_pkg::KIND_OCT:    emit_byte(oct_join(esc_count));
            default:              ;
         endcase
         esc_state = jsd_pkg::KIND_NONE;
         esc_count = '0;
      end

      if (burst_n > jsd_pkg::MAX_RESULTS) begin
         burst_n = jsd_pkg::MAX_RESULTS;
      end
      for (int k = 0; k < burst_n; k++) begin
         decoded_q.push_back('{out_byte: burst[k], out_last: r.in_last && k == burst_n - 1});
      end
   endfunction

   always @(posedge clock) begin
      jsd_pkg::rsp_type want;
      if (reset) begin
         foreach (esc_held[k]) begin
            esc_held[k] = '0;
         end
         esc_count = '0;
         esc_state = jsd_pkg::KIND_NONE;
         decoded_q.delete();
      end else begin
         // compare first: a response can never belong to a request taken on this edge
         if (rsp_pop && !rsp_empty) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response byte %02h last %0b",
                                         rsp_data.out_byte, rsp_data.out_last));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_data.out_byte, want.out_byte));
               end
               if (rsp_data.out_last !== want.out_last) begin
                  report_mismatch($sformatf("out_last %0b, expected %0b on byte %02h",
                                            rsp_data.out_last, want.out_last, want.out_byte));
               end
            end
         end
         if (req_push && !req_full) begin
            decode_request(req_data);
         end
      end
      waiting_count <= decoded_q.size();
   end

endmodule

// ===== tb/tb_js_escape_decoder.sv =====
`timescale 1ns / 100ps
// Top of the escape decoder testbench: clock, reset, request and response drivers.
// Depends on jsd_pkg, js_escape_decoder and jsd_checker.
module tb_js_escape_decoder;

   localparam int unsigned RX_HOLD_CYCLES = 150;
   localparam int unsigned DRAIN_CYCLES   = 16;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   jsd_pkg::req_type req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   jsd_pkg::rsp_type rsp_data;

   int unsigned mismatch_count;
   int unsigned waiting_count;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned sent_count    = 0;
   logic        long_hold     = 1'b0;

   logic [7:0]  enc_text [$];
   string       hex_chars     = "0123456789abcdefABCDEF";
   string       named_letters = "abfnrtv";
   string       breakers      = "gGzZq- \\";

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   js_escape_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   jsd_checker decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   initial begin
      #200_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hold push low over idle cycles, then offer until the request is taken
   task automatic push_request(input logic [7:0] b, input logic last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{in_byte: b, in_last: last};
      do begin
         @(posedge clock);
      end while (req_full);
      sent_count++;
   endtask

   task automatic send_text();
      for (int k = 0; k < enc_text.size(); k++) begin
         push_request(enc_text[k], k == enc_text.size() - 1);
      end
      enc_text.delete();
   endtask

   task automatic append_text(input string s);
      for (int k = 0; k < s.len(); k++) begin
         enc_text.push_back(s[k]);
      end
   endtask

   function automatic logic [7:0] rand_hex();
      return hex_chars[$urandom_range(21, 0)];
   endfunction

   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255, 0));
      end while (b == jsd_pkg::CH_BSLASH);
      return b;
   endfunction

   task automatic add_token();
      int unsigned pick;
      int unsigned n;
      logic [7:0]  letter;
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
         enc_text.push_back(rand_plain());
      end else if (pick < 40) begin
         enc_text.push_back(jsd_pkg::CH_BSLASH);
         if (pick < 34) begin
            enc_text.push_back(named_letters[$urandom_range(6, 0)]);
         end else begin
            enc_text.push_back(8'($urandom_range(255, 0)));
         end
      end else if (pick < 55) begin
         enc_text.push_back(jsd_pkg::CH_BSLASH);
         enc_text.push_back(jsd_pkg::CH_U);
         // favor the ff high pair so the case shift gets exercised
         if ($urandom_range(1, 0)) begin
            enc_text.push_back($urandom_range(1, 0) ? "f" : "F");
            enc_text.push_back($urandom_range(1, 0) ? "f" : "F");
         end else begin
            enc_text.push_back(rand_hex());
            enc_text.push_back(rand_hex());
         end
         enc_text.push_back(rand_hex());
         enc_text.push_back(rand_hex());
      end else if (pick < 65) begin
         enc_text.push_back(jsd_pkg::CH_BSLASH);
         enc_text.push_back(jsd_pkg::CH_X);
         enc_text.push_back(rand_hex());
         enc_text.push_back(rand_hex());
      end else if (pick < 80) begin
         enc_text.push_back(jsd_pkg::CH_BSLASH);
         n = $urandom_range(3, 1);
         for (int k = 0; k < n; k++) begin
            enc_text.push_back(jsd_pkg::CH_ZERO + 8'($urandom_range(7, 0)));
         end
      end else if (pick < 92) begin
         // broken hex escape, sometimes cut off by the end of the string
         letter = $urandom_range(1, 0) ? jsd_pkg::CH_U : jsd_pkg::CH_X;
         enc_text.push_back(jsd_pkg::CH_BSLASH);
         enc_text.push_back(letter);
         n = $urandom_range((letter == jsd_pkg::CH_U) ? 3 : 1, 0);
         for (int k = 0; k < n; k++) begin
            enc_text.push_back(rand_hex());
         end
         if ($urandom_range(9, 0) < 7) begin
            enc_text.push_back(breakers[$urandom_range(breakers.len() - 1, 0)]);
         end
      end else begin
         enc_text.push_back(8'($urandom_range(255, 0)));
      end
   endtask

   task automatic send_random_string();
      int unsigned tokens;
      tokens = $urandom_range(6, 1);
      for (int k = 0; k < tokens; k++) begin
         add_token();
      end
      if ($urandom_range(9, 0) == 0) begin
         enc_text.push_back(jsd_pkg::CH_BSLASH);
      end
      send_text();
   endtask

   task automatic run_random(input int unsigned target);
      while (sent_count < target) begin
         send_random_string();
      end
   endtask

   initial begin : receiver
      int unsigned quiet;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_pop <= 1'b0;
            // count the stall here so the sender keeps pushing meanwhile
            for (quiet = 0; quiet < RX_HOLD_CYCLES; quiet++) begin
               @(posedge clock);
            end
            long_hold = 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 66;

      // byte extremes, named and unicode escapes, then the broken and edge forms
      enc_text = '{8'h00, 8'hff};
      send_text();
      append_text("\\n\\uFf5e");
      send_text();
      append_text("\\x4g\\777\\12z\\");
      send_text();

      long_hold = 1'b1;
      run_random(100);

      send_idle_pct = 66;
      recv_idle_pct = 8;
      run_random(200);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_hold = 1'b1;
      run_random(300);
      req_push <= 1'b0;

      while (waiting_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && waiting_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
